### src/tpd_pkg.sv
// Shared types and constants for the thermal preview downsampler.
// Used by the divider and the core under src; no dependencies of its own.
package tpd_pkg;

  localparam int DEF_PREVIEW_COLS = 80;
  localparam int DEF_PREVIEW_ROWS = 60;

  localparam int PIX_W   = 16;   // source pixel width
  localparam int SUM_W   = 17;   // pair sum width
  localparam int LEVEL_W = 8;    // preview value width
  localparam int NUM_W   = 24;   // (avg-low)*255 + win/2 always fits 24 bits
  localparam int STEP_W  = 3;    // counts the LEVEL_W quotient bits

  localparam logic [PIX_W-1:0]   WIN_LOW_RST  = 16'd27315;
  localparam logic [PIX_W-1:0]   WIN_HIGH_RST = 16'd37315;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 8'd0;

  // configuration register indexes
  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAP,
    ST_DIV,
    ST_OUT
  } tpd_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/tpd_line_mem.sv
// Line store of top-row pair sums: one write port, one read port,
// registered read data. Depends on nothing but its parameters.
module tpd_line_mem #(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/tpd_level_div.sv
// Restoring divider for the window map: one quotient bit per cycle.
// Quotient is known to fit LEVEL_W bits. Uses tpd_pkg.
module tpd_level_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tpd_pkg::NUM_W-1:0]   num,
  input  logic [tpd_pkg::PIX_W-1:0]   den,
  output tpd_pkg::div_stat_t          stat,
  output logic [tpd_pkg::LEVEL_W-1:0] quot
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tpd_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [tpd_pkg::NUM_W-1:0]   rem_r, rem_nxt;
  logic [tpd_pkg::PIX_W-1:0]   den_r, den_nxt;
  logic [tpd_pkg::LEVEL_W-1:0] q_r, q_nxt;
  logic [tpd_pkg::NUM_W-1:0]   den_sh;
  logic                        fits;

  always_comb begin
    den_sh   = tpd_pkg::NUM_W'(den_r) << cnt_r;
    fits     = (rem_r >= den_sh);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tpd_pkg::STEP_W'(tpd_pkg::LEVEL_W - 1);
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      // subtract the shifted divisor where it fits, shift in the bit
      rem_nxt = fits ? rem_r - den_sh : rem_r;
      q_nxt   = {q_r[tpd_pkg::LEVEL_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

### src/thermal_preview_downsample_core.sv
// Thermal preview downsampler: 2x2 box average and window/level map to 8 bits.
// Each result passes the line store read, the map, then a clamp or the 8-step
// divider, then the output register. Throughput: 1 item per cycle except on the
// odd pixel of an odd row, which holds the input through that path plus any wait
// on out_tready. Reset: rst_n is synchronous; clears counters, window registers and
// the output valid bit. The line store is not cleared; the top row is written first.
module thermal_preview_downsample_core #(
  parameter int PREVIEW_COLS = tpd_pkg::DEF_PREVIEW_COLS,
  parameter int PREVIEW_ROWS = tpd_pkg::DEF_PREVIEW_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel_value
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] preview_value
  output logic        out_tlast,  // frame_last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int SRC_COLS = 2 * PREVIEW_COLS;
  localparam int SRC_ROWS = 2 * PREVIEW_ROWS;
  localparam int COL_W    = $clog2(SRC_COLS);
  localparam int ROW_W    = $clog2(SRC_ROWS);
  localparam int SLOT_W   = (PREVIEW_COLS > 1) ? $clog2(PREVIEW_COLS) : 1;

  localparam int PW = tpd_pkg::PIX_W;
  localparam int SW = tpd_pkg::SUM_W;
  localparam int LW = tpd_pkg::LEVEL_W;
  localparam int NW = tpd_pkg::NUM_W;

  tpd_pkg::tpd_state_t state_r, state_nxt;

  logic [COL_W-1:0]  col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]  row_r, row_nxt, row_cur;
  logic [PW-1:0]     held_r, held_nxt;
  logic [PW-1:0]     low_r, high_r;
  logic [SW-1:0]     pair_r, pair_nxt, pair_cur;
  logic              last_r, last_nxt;
  logic [PW-1:0]     avg_r, avg_nxt;
  logic [LW-1:0]     level_r, level_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LW-1:0]     out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              out_free;
  logic [SLOT_W-1:0] slot;
  logic              mem_we, mem_re;
  logic [SW-1:0]     mem_rdata;
  logic              div_start;
  logic [NW-1:0]     div_num;
  logic [PW-1:0]     win, diff;
  logic [LW-1:0]     div_quot;
  tpd_pkg::div_stat_t div_stat;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign col_cur  = in_tuser ? '0 : col_r;
  assign row_cur  = in_tuser ? '0 : row_r;
  assign slot     = SLOT_W'(col_cur >> 1);
  assign pair_cur = SW'(held_r) + SW'(in_tdata);
  assign win      = high_r - low_r;
  assign diff     = avg_r - low_r;
  // (avg - low) * 255 + win / 2
  assign div_num  = (NW'(diff) << LW) - NW'(diff) + NW'(win >> 1);

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    div_start     = 1'b0;
    col_nxt       = col_r;
    row_nxt       = row_r;
    held_nxt      = held_r;
    pair_nxt      = pair_r;
    last_nxt      = last_r;
    avg_nxt       = avg_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      tpd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (col_cur == COL_W'(SRC_COLS - 1)) begin
            col_nxt = '0;
            row_nxt = (row_cur == ROW_W'(SRC_ROWS - 1)) ? '0 : row_cur + 1'b1;
          end else begin
            col_nxt = col_cur + 1'b1;
            row_nxt = row_cur;
          end
          if (!col_cur[0]) begin
            held_nxt = in_tdata;
          end else if (!row_cur[0]) begin
            mem_we = 1'b1;
          end else begin
            // bottom row: fetch the top pair sum
            mem_re    = 1'b1;
            pair_nxt  = pair_cur;
            last_nxt  = (col_cur == COL_W'(SRC_COLS - 1)) &&
                        (row_cur == ROW_W'(SRC_ROWS - 1));
            state_nxt = tpd_pkg::ST_READ;
          end
        end
      end
      tpd_pkg::ST_READ: begin
        avg_nxt   = PW'((19'(mem_rdata) + 19'(pair_r) + 19'd2) >> 2);
        state_nxt = tpd_pkg::ST_MAP;
      end
      tpd_pkg::ST_MAP: begin
        priority if (avg_r >= high_r) begin
          level_nxt = tpd_pkg::LEVEL_MAX;
          state_nxt = tpd_pkg::ST_OUT;
        end else if (avg_r <= low_r) begin
          level_nxt = tpd_pkg::LEVEL_MIN;
          state_nxt = tpd_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = tpd_pkg::ST_DIV;
        end
      end
      tpd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          level_nxt = div_quot;
          state_nxt = tpd_pkg::ST_OUT;
        end
      end
      tpd_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = level_r;
          out_last_nxt  = last_r;
          state_nxt     = tpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpd_pkg::ST_IDLE;
    endcase
    if (!accept) begin
      col_nxt = col_r;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= tpd_pkg::WIN_LOW_RST;
      high_r <= tpd_pkg::WIN_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tpd_pkg::REG_WINDOW_LOW:  low_r  <= cfg_wdata;
        tpd_pkg::REG_WINDOW_HIGH: high_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pair_r     <= pair_nxt;
    last_r     <= last_nxt;
    avg_r      <= avg_nxt;
    level_r    <= level_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  tpd_line_mem #(
    .DEPTH  (PREVIEW_COLS),
    .ADDR_W (SLOT_W),
    .DATA_W (SW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (pair_cur),
    .re    (mem_re),
    .raddr (slot),
    .rdata (mem_rdata)
  );

  tpd_level_div u_level_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (win),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // divider only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == tpd_pkg::ST_DIV)
    else $error("divider done outside divide state");

  // a bottom-row odd pixel must go fetch its top pair sum
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && col_cur[0] && row_cur[0]) |=> state_r == tpd_pkg::ST_READ)
    else $error("result item did not start line store read");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpd_pkg::ST_OUT && out_valid_r && !out_tready)
      |=> state_r == tpd_pkg::ST_OUT)
    else $error("output register overwritten while stalled");

  // column position stays inside the source line
  assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(SRC_COLS - 1))
    else $error("column counter out of range");

endmodule
